// File: rtl/udprx_pkg.sv
// udprx_pkg: types, constants and checksum helpers for the ipv4/udp receive checker
// used by udprx_accum, udprx_verdict and ipv4_udp_dhcp_rx_checker; no dependencies
package udprx_pkg;

  // frame limits
  localparam logic [9:0] MAX_FRAME_BYTES = 10'd576;
  localparam logic [9:0] COOKIE_OFFSET   = 10'd264;

  // udp protocol number, required version and header length
  localparam logic [7:0] PROTO_UDP   = 8'd17;
  localparam logic [3:0] IP_VERSION  = 4'd4;
  localparam logic [3:0] IP_IHL      = 4'd5;
  localparam logic [9:0] MIN_BYTES   = 10'd28;
  localparam logic [15:0] ONES_MASK  = 16'hffff;

  // register reset values
  localparam logic [15:0] CLIENT_PORT_RESET = 16'd68;
  localparam logic [31:0] COOKIE_RESET      = 32'h6382_5363;

  // register indexes (address bit 2)
  localparam logic REG_CLIENT_PORT = 1'b0;
  localparam logic REG_COOKIE      = 1'b1;

  // verdict codes
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_SHORT     = 4'd1;
  localparam logic [3:0] ST_TRUNCATED = 4'd2;
  localparam logic [3:0] ST_TOO_LONG  = 4'd3;
  localparam logic [3:0] ST_PROTO     = 4'd4;
  localparam logic [3:0] ST_IHL       = 4'd5;
  localparam logic [3:0] ST_PORT      = 4'd6;
  localparam logic [3:0] ST_UDP_LEN   = 4'd7;
  localparam logic [3:0] ST_IP_SUM    = 4'd8;
  localparam logic [3:0] ST_UDP_SUM   = 4'd9;
  localparam logic [3:0] ST_COOKIE    = 4'd10;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [3:0] status;
    logic [9:0] payload_length;
  } out_word_t;

  // running per-frame state
  typedef struct packed {
    logic [9:0]  byte_count;
    logic [7:0]  pending_high_byte;
    logic [16:0] ip_sum;
    logic [16:0] udp_sum;
    logic [15:0] total_length;
    logic [7:0]  version_ihl;
    logic [7:0]  protocol_seen;
    logic [15:0] ip_check_seen;
    logic [15:0] dest_port_seen;
    logic [15:0] udp_length_seen;
    logic [15:0] udp_check_seen;
    logic [31:0] cookie_seen;
  } frame_state_t;

  // ones'-complement add with end-around carry
  function automatic logic [16:0] ones_add(input logic [16:0] s, input logic [15:0] w);
    logic [17:0] sum;
    logic [16:0] res;
    sum = {1'b0, s} + {2'b00, w};
    if (sum > {2'b00, ONES_MASK}) begin
      res = {1'b0, sum[15:0]} + 17'd1;
    end else begin
      res = sum[16:0];
    end
    return res;
  endfunction

  // byte value as the udp pseudo-header sum sees it
  function automatic logic [7:0] pseudo_byte(input logic [9:0] idx, input logic [7:0] raw);
    logic [7:0] res;
    if (idx >= 10'd4 && idx < 10'd12) begin
      res = (idx == 10'd9) ? PROTO_UDP : 8'd0;
    end else if (idx == 10'd26 || idx == 10'd27) begin
      res = 8'd0;
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage

// File: rtl/udprx_accum.sv
// udprx_accum: per-byte header capture and running checksums for one frame
// depends on udprx_pkg
module udprx_accum (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    take,
  input  udprx_pkg::in_word_t     in_word,
  output udprx_pkg::frame_state_t state_next
);

  udprx_pkg::frame_state_t frame;

  always_comb begin
    logic [9:0]  i;
    logic [7:0]  b;
    logic [15:0] ip_w;
    logic [7:0]  hi;
    logic [7:0]  lo;
    i = frame.byte_count;
    b = in_word.data_byte;
    ip_w = 16'd0;
    hi = 8'd0;
    lo = 8'd0;
    state_next = frame;
    if (i < udprx_pkg::MAX_FRAME_BYTES) begin
      state_next.byte_count = i + 10'd1;
      if (i == 10'd0) state_next.version_ihl = b;
      if (i == 10'd2 || i == 10'd3) state_next.total_length = {frame.total_length[7:0], b};
      if (i == 10'd9) state_next.protocol_seen = b;
      if (i == 10'd10 || i == 10'd11) state_next.ip_check_seen = {frame.ip_check_seen[7:0], b};
      if (i == 10'd22 || i == 10'd23) state_next.dest_port_seen = {frame.dest_port_seen[7:0], b};
      if (i == 10'd24 || i == 10'd25) begin
        state_next.udp_length_seen = {frame.udp_length_seen[7:0], b};
      end
      if (i == 10'd26 || i == 10'd27) begin
        state_next.udp_check_seen = {frame.udp_check_seen[7:0], b};
      end
      if ({1'b0, i} >= {1'b0, udprx_pkg::COOKIE_OFFSET} &&
          {1'b0, i} < ({1'b0, udprx_pkg::COOKIE_OFFSET} + 11'd4)) begin
        state_next.cookie_seen = {frame.cookie_seen[23:0], b};
      end
      if (!i[0]) begin
        state_next.pending_high_byte = b;
      end else begin
        // ip header words, checksum field counts as zero
        if (i < 10'd20) begin
          ip_w = (i == 10'd11) ? 16'd0 : {frame.pending_high_byte, b};
          state_next.ip_sum = udprx_pkg::ones_add(frame.ip_sum, ip_w);
        end
        // udp sum over the pseudo-header layout, bounded by total length
        if (i >= 10'd5) begin
          if ({6'd0, i - 10'd1} < frame.total_length) begin
            hi = udprx_pkg::pseudo_byte(i - 10'd1, frame.pending_high_byte);
          end
          if ({6'd0, i} < frame.total_length) begin
            lo = udprx_pkg::pseudo_byte(i, b);
          end
          state_next.udp_sum = udprx_pkg::ones_add(frame.udp_sum, {hi, lo});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame <= '0;
    end else if (take) begin
      frame <= in_word.last_byte ? '0 : state_next;
    end
  end

endmodule

// File: rtl/udprx_verdict.sv
// udprx_verdict: ordered checks on a finished frame, gives status and payload length
// depends on udprx_pkg
module udprx_verdict (
  input  udprx_pkg::frame_state_t frame,
  input  logic [15:0]             client_port,
  input  logic [31:0]             expected_cookie,
  output udprx_pkg::out_word_t    result
);

  always_comb begin
    logic [15:0] tl;
    logic [9:0]  idx;
    logic [16:0] us;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [3:0]  st;
    tl = frame.total_length;
    idx = frame.byte_count - 10'd1;
    us = frame.udp_sum;
    hi = 8'd0;
    lo = 8'd0;
    // trailing odd byte padded with a zero low byte
    if (frame.byte_count[0] && ({6'd0, idx} < tl)) begin
      us = udprx_pkg::ones_add(us, {udprx_pkg::pseudo_byte(idx, frame.pending_high_byte), 8'd0});
    end
    // pseudo-header udp length word
    if (tl > 16'd2) hi = frame.udp_length_seen[15:8];
    if (tl > 16'd3) lo = frame.udp_length_seen[7:0];
    us = udprx_pkg::ones_add(us, {hi, lo});

    if (frame.byte_count < udprx_pkg::MIN_BYTES) begin
      st = udprx_pkg::ST_SHORT;
    end else if ({6'd0, frame.byte_count} < tl) begin
      st = udprx_pkg::ST_TRUNCATED;
    end else if (tl > {6'd0, udprx_pkg::MAX_FRAME_BYTES}) begin
      st = udprx_pkg::ST_TOO_LONG;
    end else if (frame.protocol_seen != udprx_pkg::PROTO_UDP ||
                 frame.version_ihl[7:4] != udprx_pkg::IP_VERSION) begin
      st = udprx_pkg::ST_PROTO;
    end else if (frame.version_ihl[3:0] != udprx_pkg::IP_IHL) begin
      st = udprx_pkg::ST_IHL;
    end else if (frame.dest_port_seen != client_port) begin
      st = udprx_pkg::ST_PORT;
    end else if (frame.udp_length_seen != (tl - 16'd20)) begin
      st = udprx_pkg::ST_UDP_LEN;
    end else if (frame.ip_check_seen != ~frame.ip_sum[15:0]) begin
      st = udprx_pkg::ST_IP_SUM;
    end else if (frame.udp_check_seen != 16'd0 && frame.udp_check_seen != ~us[15:0]) begin
      st = udprx_pkg::ST_UDP_SUM;
    end else if (tl < ({6'd0, udprx_pkg::COOKIE_OFFSET} + 16'd4)) begin
      st = udprx_pkg::ST_COOKIE;
    end else if (frame.cookie_seen != expected_cookie) begin
      st = udprx_pkg::ST_COOKIE;
    end else begin
      st = udprx_pkg::ST_OK;
    end

    result.status = st;
    result.payload_length = (st == udprx_pkg::ST_OK) ? 10'(tl - 16'd28) : 10'd0;
  end

endmodule

// File: rtl/ipv4_udp_dhcp_rx_checker.sv
// ipv4_udp_dhcp_rx_checker: top level of the ipv4/udp receive checker for dhcp frames
// depends on udprx_pkg, udprx_accum and udprx_verdict
//
// Takes a received ipv4 datagram one byte per word, in network order, with
// last_byte set on the final byte, and returns one verdict word per datagram:
// a status (0 ok, then the first failing check in order: short, truncated,
// too long, protocol/version, ihl, destination port, udp length, ip header
// checksum, udp checksum, magic cookie) and the dhcp payload length, which is
// total length minus 28 when the status is ok and zero otherwise. One byte is
// taken every clock cycle, back to back across datagram boundaries, unless a
// last byte waits for room in the snapshot stage; the verdict passes from the
// input register through the end-of-frame snapshot to the verdict register,
// and that snapshot frees the accumulator for the next datagram at once. Bytes
// beyond the 576-byte maximum are dropped, though their last_byte flag still
// closes the frame. The udp destination port (address 0, reset 68) and the
// expected magic cookie (address 4, reset 0x63825363) sit behind a small apb
// port and should only be written while no datagram is in flight.
module ipv4_udp_dhcp_rx_checker (
  input  logic                  clk,
  input  logic                  rst,
  // byte input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  udprx_pkg::in_word_t   in_data,
  // verdict output channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output udprx_pkg::out_word_t  out_data,
  // apb register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // configuration registers
  logic [15:0] client_port;
  logic [31:0] expected_cookie;

  // stage 1: input register
  logic                 s1_valid;
  udprx_pkg::in_word_t  s1_word;
  // stage 2: finished-frame snapshot
  logic                    s2_valid;
  udprx_pkg::frame_state_t s2_frame;
  // stage 3: verdict register, drives the output
  logic                 s3_valid;
  udprx_pkg::out_word_t s3_word;

  udprx_pkg::frame_state_t state_next;
  udprx_pkg::out_word_t    verdict_word;

  logic s3_load_ok;
  logic s2_move;
  logic s2_load_ok;
  logic s1_take;
  logic in_fire;
  logic cfg_write;

  // ---------------------------------------------------------------------
  // register port: writes on the access phase, reads are combinational
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      client_port     <= udprx_pkg::CLIENT_PORT_RESET;
      expected_cookie <= udprx_pkg::COOKIE_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        udprx_pkg::REG_CLIENT_PORT: client_port     <= pwdata[15:0];
        udprx_pkg::REG_COOKIE:      expected_cookie <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      udprx_pkg::REG_CLIENT_PORT: prdata = {16'd0, client_port};
      udprx_pkg::REG_COOKIE:      prdata = expected_cookie;
      default:                    prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------
  // flow control: each stage refills as soon as it empties or moves on;
  // only a last byte needs room in the snapshot stage
  // ---------------------------------------------------------------------
  assign s3_load_ok = !s3_valid || !out_stall;
  assign s2_move    = s2_valid && s3_load_ok;
  assign s2_load_ok = !s2_valid || s2_move;
  assign s1_take    = s1_valid && (!s1_word.last_byte || s2_load_ok);
  assign in_stall   = s1_valid && !s1_take;
  assign in_fire    = in_valid && !in_stall;

  assign out_valid = s3_valid;
  assign out_data  = s3_word;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_word <= in_data;
    end
  end

  // byte accumulate: captures header fields and keeps both running sums
  udprx_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .take       (s1_take),
    .in_word    (s1_word),
    .state_next (state_next)
  );

  // snapshot of the frame state including its last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_take && s1_word.last_byte) begin
      s2_valid <= 1'b1;
    end else if (s2_move) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && s1_word.last_byte) begin
      s2_frame <= state_next;
    end
  end

  // ordered checks and final checksum folding
  udprx_verdict u_verdict (
    .frame           (s2_frame),
    .client_port     (client_port),
    .expected_cookie (expected_cookie),
    .result          (verdict_word)
  );

  // verdict register
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s2_move) begin
      s3_valid <= 1'b1;
    end else if (!out_stall) begin
      s3_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      s3_word <= verdict_word;
    end
  end

endmodule
